>>> rtl/pab_pkg.sv
// Shared types, constants and helper functions for the pixel alpha blend block.
// Used by every module of the block; depends on nothing else.
package pab_pkg;

    localparam int NUM_STAGES = 5;

    // Configuration register indexes (byte address / 4).
    localparam logic [2:0] REG_RED_SHIFT     = 3'd0;
    localparam logic [2:0] REG_RED_SIZE      = 3'd1;
    localparam logic [2:0] REG_GREEN_SHIFT   = 3'd2;
    localparam logic [2:0] REG_GREEN_SIZE    = 3'd3;
    localparam logic [2:0] REG_BLUE_SHIFT    = 3'd4;
    localparam logic [2:0] REG_BLUE_SIZE     = 3'd5;
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd6;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd7;

    localparam logic [4:0]  RST_RED_SHIFT     = 5'd16;
    localparam logic [3:0]  RST_RED_SIZE      = 4'd8;
    localparam logic [4:0]  RST_GREEN_SHIFT   = 5'd8;
    localparam logic [3:0]  RST_GREEN_SIZE    = 4'd8;
    localparam logic [4:0]  RST_BLUE_SHIFT    = 5'd0;
    localparam logic [3:0]  RST_BLUE_SIZE     = 4'd8;
    localparam logic [14:0] RST_SCREEN_WIDTH  = 15'd640;
    localparam logic [14:0] RST_SCREEN_HEIGHT = 15'd480;

    localparam logic [3:0] FULL_SIZE = 4'd8;
    localparam logic [7:0] ALPHA_MAX = 8'd255;
    localparam logic [15:0] ROUND_BIAS = 16'd127;

    // Widening v*255/mask is done as (v * ceil(255 * 2^24 / mask)) >> 24.
    // The error stays below 1/mask, so the floor is exact for every field size.
    localparam int FRAC_BITS = 24;
    localparam logic [63:0] WIDEN_NUM = 64'd255 << FRAC_BITS;
    localparam logic [31:0] WIDEN_MUL_1 = 32'((WIDEN_NUM + 64'd0) / 64'd1);
    localparam logic [31:0] WIDEN_MUL_2 = 32'((WIDEN_NUM + 64'd2) / 64'd3);
    localparam logic [31:0] WIDEN_MUL_3 = 32'((WIDEN_NUM + 64'd6) / 64'd7);
    localparam logic [31:0] WIDEN_MUL_4 = 32'((WIDEN_NUM + 64'd14) / 64'd15);
    localparam logic [31:0] WIDEN_MUL_5 = 32'((WIDEN_NUM + 64'd30) / 64'd31);
    localparam logic [31:0] WIDEN_MUL_6 = 32'((WIDEN_NUM + 64'd62) / 64'd63);
    localparam logic [31:0] WIDEN_MUL_7 = 32'((WIDEN_NUM + 64'd126) / 64'd127);

    // Division by 255 of the blend sum as a multiply by ceil(2^24 / 255).
    localparam logic [16:0] RECIP_255 = 17'(((64'd1 << FRAC_BITS) + 64'd254) / 64'd255);

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } pipe_ctrl_t;

    typedef struct packed {
        logic        on_screen;
        logic        alpha_zero;
        logic        alpha_full;
        logic [31:0] source;
    } side_t;

    function automatic logic [3:0] clamp_size(input logic [3:0] size);
        logic [3:0] res;
        res = (size > FULL_SIZE) ? FULL_SIZE : size;
        return res;
    endfunction

    function automatic logic [31:0] widen_mul(input logic [3:0] sz);
        logic [31:0] res;
        case (sz)
            4'd1:    res = WIDEN_MUL_1;
            4'd2:    res = WIDEN_MUL_2;
            4'd3:    res = WIDEN_MUL_3;
            4'd4:    res = WIDEN_MUL_4;
            4'd5:    res = WIDEN_MUL_5;
            4'd6:    res = WIDEN_MUL_6;
            4'd7:    res = WIDEN_MUL_7;
            default: res = 32'd0;
        endcase
        return res;
    endfunction

    // Narrow an 8-bit channel to its field and place it in the pixel word.
    function automatic logic [31:0] pack_chan(input logic [7:0] v8, input logic [3:0] sz,
                                              input logic [4:0] shift);
        logic [7:0]  v;
        logic [31:0] res;
        v = v8 >> (FULL_SIZE - sz);
        res = (sz == 4'd0) ? 32'd0 : ({24'd0, v} << shift);
        return res;
    endfunction

endpackage

>>> rtl/pixel_alpha_blend.sv
// Top level of the pixel alpha blend block: configuration registers, bounds check,
// pipeline side data, channel packing and the output register.
// Depends on pab_pkg, pab_ctrl and pab_channel.
//
// Usage: a pixel transaction (coordinate, source color, alpha, destination color)
// enters on the s_ valid/ready channel; the result (in_bounds, write_enable,
// write_color) leaves on the m_ valid/ready channel, one result per pixel, in order.
// The pipeline has five register stages: extract, widen, weighted sum, divide by
// 255, and pack into the output register. One pixel is accepted every cycle as
// long as the receiver keeps up. When m_ready is low the output register holds
// its result, and earlier stages keep moving until the pipeline is full; then
// s_ready drops. Nothing is lost or repeated across a stall.
// Pixel format and screen size come from eight APB registers at byte addresses
// 0x00..0x1C; they may only be written while no transaction is in flight.
// Reset (aresetn low, synchronous) empties the pipeline and restores the default
// 32-bit RGB888 format on a 640 x 480 screen.
module pixel_alpha_blend (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_pos_x,
    input  logic signed [15:0] s_pos_y,
    input  logic [31:0]        s_source_color,
    input  logic [7:0]         s_alpha,
    input  logic [31:0]        s_dest_color,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_in_bounds,
    output logic               m_write_enable,
    output logic [31:0]        m_write_color
);

    // Configuration registers.
    logic [4:0]  red_shift_reg;
    logic [3:0]  red_size_reg;
    logic [4:0]  green_shift_reg;
    logic [3:0]  green_size_reg;
    logic [4:0]  blue_shift_reg;
    logic [3:0]  blue_size_reg;
    logic [14:0] screen_width_reg;
    logic [14:0] screen_height_reg;
    logic [2:0]  reg_index;
    logic        cfg_write;

    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_shift_reg     <= pab_pkg::RST_RED_SHIFT;
            red_size_reg      <= pab_pkg::RST_RED_SIZE;
            green_shift_reg   <= pab_pkg::RST_GREEN_SHIFT;
            green_size_reg    <= pab_pkg::RST_GREEN_SIZE;
            blue_shift_reg    <= pab_pkg::RST_BLUE_SHIFT;
            blue_size_reg     <= pab_pkg::RST_BLUE_SIZE;
            screen_width_reg  <= pab_pkg::RST_SCREEN_WIDTH;
            screen_height_reg <= pab_pkg::RST_SCREEN_HEIGHT;
        end else if (cfg_write) begin
            case (reg_index)
                pab_pkg::REG_RED_SHIFT:     red_shift_reg     <= pwdata[4:0];
                pab_pkg::REG_RED_SIZE:      red_size_reg      <= pwdata[3:0];
                pab_pkg::REG_GREEN_SHIFT:   green_shift_reg   <= pwdata[4:0];
                pab_pkg::REG_GREEN_SIZE:    green_size_reg    <= pwdata[3:0];
                pab_pkg::REG_BLUE_SHIFT:    blue_shift_reg    <= pwdata[4:0];
                pab_pkg::REG_BLUE_SIZE:     blue_size_reg     <= pwdata[3:0];
                pab_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[14:0];
                pab_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            pab_pkg::REG_RED_SHIFT:     prdata = {27'd0, red_shift_reg};
            pab_pkg::REG_RED_SIZE:      prdata = {28'd0, red_size_reg};
            pab_pkg::REG_GREEN_SHIFT:   prdata = {27'd0, green_shift_reg};
            pab_pkg::REG_GREEN_SIZE:    prdata = {28'd0, green_size_reg};
            pab_pkg::REG_BLUE_SHIFT:    prdata = {27'd0, blue_shift_reg};
            pab_pkg::REG_BLUE_SIZE:     prdata = {28'd0, blue_size_reg};
            pab_pkg::REG_SCREEN_WIDTH:  prdata = {17'd0, screen_width_reg};
            pab_pkg::REG_SCREEN_HEIGHT: prdata = {17'd0, screen_height_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // Pipeline control.
    pab_pkg::pipe_ctrl_t ctrl;

    pab_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    // Bounds check and alpha classification at the input; a negative
    // coordinate has its sign bit set and is always off screen.
    pab_pkg::side_t side_in;
    pab_pkg::side_t side_reg [0:3];

    assign side_in.on_screen  = !s_pos_x[15] && !s_pos_y[15]
                                && (s_pos_x[14:0] < screen_width_reg)
                                && (s_pos_y[14:0] < screen_height_reg);
    assign side_in.alpha_zero = (s_alpha == 8'd0);
    assign side_in.alpha_full = (s_alpha == pab_pkg::ALPHA_MAX);
    assign side_in.source     = s_source_color;

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            side_reg[0] <= side_in;
        end
        for (int i = 1; i < 4; i++) begin
            if (ctrl.load[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Channel datapaths.
    logic [7:0] red_blend;
    logic [7:0] green_blend;
    logic [7:0] blue_blend;

    pab_channel u_red (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .src_word   (s_source_color),
        .dst_word   (s_dest_color),
        .alpha      (s_alpha),
        .chan_size  (red_size_reg),
        .chan_shift (red_shift_reg),
        .blended    (red_blend)
    );

    pab_channel u_green (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .src_word   (s_source_color),
        .dst_word   (s_dest_color),
        .alpha      (s_alpha),
        .chan_size  (green_size_reg),
        .chan_shift (green_shift_reg),
        .blended    (green_blend)
    );

    pab_channel u_blue (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .src_word   (s_source_color),
        .dst_word   (s_dest_color),
        .alpha      (s_alpha),
        .chan_size  (blue_size_reg),
        .chan_shift (blue_shift_reg),
        .blended    (blue_blend)
    );

    // Repack, select the result and register it.
    logic [31:0] packed_color;
    logic [31:0] color_sel;
    logic        in_bounds_reg;
    logic        write_enable_reg;
    logic [31:0] write_color_reg;

    assign packed_color =
        pab_pkg::pack_chan(red_blend, pab_pkg::clamp_size(red_size_reg), red_shift_reg)
        | pab_pkg::pack_chan(green_blend, pab_pkg::clamp_size(green_size_reg),
                             green_shift_reg)
        | pab_pkg::pack_chan(blue_blend, pab_pkg::clamp_size(blue_size_reg),
                             blue_shift_reg);

    always_comb begin
        if (!side_reg[3].on_screen || side_reg[3].alpha_zero) begin
            color_sel = 32'd0;
        end else if (side_reg[3].alpha_full) begin
            color_sel = side_reg[3].source;
        end else begin
            color_sel = packed_color;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[4]) begin
            in_bounds_reg    <= side_reg[3].on_screen;
            write_enable_reg <= side_reg[3].on_screen && !side_reg[3].alpha_zero;
            write_color_reg  <= color_sel;
        end
    end

    assign m_valid        = ctrl.valid[pab_pkg::NUM_STAGES-1];
    assign m_in_bounds    = in_bounds_reg;
    assign m_write_enable = write_enable_reg;
    assign m_write_color  = write_color_reg;

endmodule

>>> rtl/pab_ctrl.sv
// Valid tracking and stage load enables for the pixel alpha blend pipeline.
// Depends on pab_pkg.
module pab_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                m_ready,
    output pab_pkg::pipe_ctrl_t ctrl
);

    logic [pab_pkg::NUM_STAGES-1:0] valid_reg;
    logic [pab_pkg::NUM_STAGES-1:0] valid_next;
    logic [pab_pkg::NUM_STAGES-1:0] adv;

    // A stage may load when it is empty or its content moves on this cycle,
    // so bubbles are squeezed out while the output waits.
    always_comb begin
        adv[pab_pkg::NUM_STAGES-1] = !valid_reg[pab_pkg::NUM_STAGES-1] || m_ready;
        for (int i = pab_pkg::NUM_STAGES - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (adv[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < pab_pkg::NUM_STAGES; i++) begin
            if (adv[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready    = adv[0];
    assign ctrl.load  = adv;
    assign ctrl.valid = valid_reg;

endmodule

>>> rtl/pab_channel.sv
// Datapath of one color channel: extract, widen to 8 bits, blend and divide by 255.
// Four register stages driven by the load enables from pab_ctrl; depends on pab_pkg.
module pab_channel (
    input  logic                aclk,
    input  pab_pkg::pipe_ctrl_t ctrl,
    input  logic [31:0]         src_word,
    input  logic [31:0]         dst_word,
    input  logic [7:0]          alpha,
    input  logic [3:0]          chan_size,
    input  logic [4:0]          chan_shift,
    output logic [7:0]          blended
);

    // Stage 1: field extraction.
    logic [3:0]  sz_c;
    logic [7:0]  field_mask;
    logic [31:0] src_sh;
    logic [31:0] dst_sh;
    logic [7:0]  src_v_reg;
    logic [7:0]  dst_v_reg;
    logic [7:0]  alpha1_reg;
    logic [3:0]  sz1_reg;

    assign sz_c       = pab_pkg::clamp_size(chan_size);
    assign field_mask = 8'hFF >> (pab_pkg::FULL_SIZE - sz_c);
    assign src_sh     = src_word >> chan_shift;
    assign dst_sh     = dst_word >> chan_shift;

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            src_v_reg  <= src_sh[7:0] & field_mask;
            dst_v_reg  <= dst_sh[7:0] & field_mask;
            alpha1_reg <= alpha;
            sz1_reg    <= sz_c;
        end
    end

    // Stage 2: widening to 8 bits.
    logic [31:0] mul_k;
    logic [39:0] src_prod;
    logic [39:0] dst_prod;
    logic [7:0]  src_w;
    logic [7:0]  dst_w;
    logic [7:0]  src_w_reg;
    logic [7:0]  dst_w_reg;
    logic [7:0]  alpha2_reg;

    assign mul_k    = pab_pkg::widen_mul(sz1_reg);
    assign src_prod = {32'd0, src_v_reg} * {8'd0, mul_k};
    assign dst_prod = {32'd0, dst_v_reg} * {8'd0, mul_k};
    assign src_w    = (sz1_reg == pab_pkg::FULL_SIZE) ? src_v_reg : src_prod[31:24];
    assign dst_w    = (sz1_reg == pab_pkg::FULL_SIZE) ? dst_v_reg : dst_prod[31:24];

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            src_w_reg  <= src_w;
            dst_w_reg  <= dst_w;
            alpha2_reg <= alpha1_reg;
        end
    end

    // Stage 3: weighted sum with rounding bias; the maximum 65152 fits 16 bits.
    logic [15:0] src_term;
    logic [15:0] dst_term;
    logic [7:0]  inv_alpha;
    logic [15:0] sum_reg;

    assign inv_alpha = pab_pkg::ALPHA_MAX - alpha2_reg;
    assign src_term  = {8'd0, src_w_reg} * {8'd0, alpha2_reg};
    assign dst_term  = {8'd0, dst_w_reg} * {8'd0, inv_alpha};

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            sum_reg <= src_term + dst_term + pab_pkg::ROUND_BIAS;
        end
    end

    // Stage 4: divide by 255 through the reciprocal.
    logic [32:0] div_prod;
    logic [7:0]  blend_reg;

    assign div_prod = {17'd0, sum_reg} * {16'd0, pab_pkg::RECIP_255};

    always_ff @(posedge aclk) begin
        if (ctrl.load[3]) begin
            blend_reg <= div_prod[31:24];
        end
    end

    assign blended = blend_reg;

endmodule

>>> sim/tb_pixel_alpha_blend.sv
// Self-checking testbench for the pixel alpha blend block: predicts each blended
// pixel in SystemVerilog and compares it with the block's output transactions.
// Depends on pab_pkg and pixel_alpha_blend from the rtl folder.
module tb_pixel_alpha_blend;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        src;
        logic [7:0]         alpha;
        logic [31:0]        dst;
    } pixel_t;

    typedef struct {
        logic        in_bounds;
        logic        write_enable;
        logic [31:0] write_color;
    } blend_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_pos_x = '0;
    logic signed [15:0] s_pos_y = '0;
    logic [31:0]        s_source_color = '0;
    logic [7:0]         s_alpha = '0;
    logic [31:0]        s_dest_color = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_in_bounds;
    logic               m_write_enable;
    logic [31:0]        m_write_color;

    // Pixel format and screen size as the block should currently hold them.
    logic [4:0]  chan_shift [3];
    logic [3:0]  chan_size [3];
    logic [14:0] scr_width;
    logic [14:0] scr_height;

    blend_result_t pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int error_count = 0;
    int pixel_count = 0;
    int format_count = 0;
    int stall_cycles = 0;
    int cycle_count = 0;

    pixel_alpha_blend dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_source_color (s_source_color),
        .s_alpha        (s_alpha),
        .s_dest_color   (s_dest_color),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_in_bounds    (m_in_bounds),
        .m_write_enable (m_write_enable),
        .m_write_color  (m_write_color)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Extract a channel field and scale it to the full 8-bit range.
    function automatic logic [7:0] field_to_8bit(input logic [31:0] word,
                                                 input logic [3:0] size,
                                                 input logic [4:0] shift);
        int unsigned sz;
        int unsigned mask;
        int unsigned v;
        sz = (size > 4'd8) ? 8 : size;
        if (sz == 0)
            return 8'd0;
        mask = (1 << sz) - 1;
        v = (word >> shift) & mask;
        if (sz == 8)
            return v[7:0];
        return 8'((v * 255) / mask);
    endfunction

    function automatic logic [31:0] field_from_8bit(input logic [7:0] v8,
                                                    input logic [3:0] size,
                                                    input logic [4:0] shift);
        int unsigned sz;
        logic [31:0] v;
        sz = (size > 4'd8) ? 8 : size;
        if (sz == 0)
            return 32'd0;
        v = {24'd0, v8} >> (8 - sz);
        return v << shift;
    endfunction

    function automatic logic [7:0] blend_mix(input logic [7:0] s, input logic [7:0] d,
                                             input logic [7:0] a);
        int unsigned sum;
        sum = int'(s) * int'(a) + int'(d) * (255 - int'(a)) + 127;
        return 8'(sum / 255);
    endfunction

    function automatic blend_result_t predict_blend(input pixel_t px);
        blend_result_t res;
        logic [7:0] s8;
        logic [7:0] d8;
        res.in_bounds = (px.x >= 0) && (px.y >= 0) &&
                        (int'(px.x) < int'(scr_width)) && (int'(px.y) < int'(scr_height));
        res.write_enable = 1'b0;
        res.write_color = '0;
        if (!res.in_bounds || px.alpha == 8'd0)
            return res;
        res.write_enable = 1'b1;
        if (px.alpha == pab_pkg::ALPHA_MAX) begin
            res.write_color = px.src;
            return res;
        end
        // Only the repacked channels survive; overlapping fields merge by OR.
        for (int c = 0; c < 3; c++) begin
            s8 = field_to_8bit(px.src, chan_size[c], chan_shift[c]);
            d8 = field_to_8bit(px.dst, chan_size[c], chan_shift[c]);
            res.write_color |= field_from_8bit(blend_mix(s8, d8, px.alpha),
                                               chan_size[c], chan_shift[c]);
        end
        return res;
    endfunction

    function automatic pixel_t make_pixel(input int x, input int y, input logic [31:0] src,
                                          input logic [7:0] alpha, input logic [31:0] dst);
        pixel_t px;
        px.x = 16'(x);
        px.y = 16'(y);
        px.src = src;
        px.alpha = alpha;
        px.dst = dst;
        return px;
    endfunction

    // Mostly on screen, some near the edges, some anywhere in the 16-bit range.
    function automatic logic signed [15:0] random_coord(input logic [14:0] extent);
        int v;
        case ($urandom_range(7))
            0: v = $urandom_range(65535);
            1: v = int'(extent) - 2 + $urandom_range(3);
            default: v = (extent == 0) ? $urandom_range(3) : $urandom_range(int'(extent) - 1);
        endcase
        return 16'(v);
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        px.x = random_coord(scr_width);
        px.y = random_coord(scr_height);
        px.src = $urandom;
        px.dst = $urandom;
        case ($urandom_range(9))
            0: px.alpha = 8'd0;
            1: px.alpha = pab_pkg::ALPHA_MAX;
            default: px.alpha = 8'($urandom_range(255));
        endcase
        return px;
    endfunction

    always @(posedge aclk) begin
        blend_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no pixel pending: in_bounds %0b write_enable %0b color %08h",
                       m_in_bounds, m_write_enable, m_write_color);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_in_bounds !== want.in_bounds) begin
                    $error("in_bounds: expected %0b, got %0b", want.in_bounds, m_in_bounds);
                    error_count++;
                end
                if (m_write_enable !== want.write_enable) begin
                    $error("write_enable: expected %0b, got %0b",
                           want.write_enable, m_write_enable);
                    error_count++;
                end
                if (m_write_color !== want.write_color) begin
                    $error("write_color: expected %08h, got %08h",
                           want.write_color, m_write_color);
                    error_count++;
                end
            end
        end
        if (hold_left > 0)
            hold_left--;
        m_ready <= (hold_left > 0) ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_pixel(input pixel_t px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_pos_x        <= px.x;
        s_pos_y        <= px.y;
        s_source_color <= px.src;
        s_alpha        <= px.alpha;
        s_dest_color   <= px.dst;
        @(posedge aclk);
        while (!s_ready) begin
            stall_cycles++;
            @(posedge aclk);
        end
        pending_results.push_back(predict_blend(px));
        pixel_count++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Back-to-back APB writes: the next setup phase follows the access phase directly.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        case (idx)
            pab_pkg::REG_RED_SHIFT:     chan_shift[CH_RED] = value[4:0];
            pab_pkg::REG_RED_SIZE:      chan_size[CH_RED] = value[3:0];
            pab_pkg::REG_GREEN_SHIFT:   chan_shift[CH_GREEN] = value[4:0];
            pab_pkg::REG_GREEN_SIZE:    chan_size[CH_GREEN] = value[3:0];
            pab_pkg::REG_BLUE_SHIFT:    chan_shift[CH_BLUE] = value[4:0];
            pab_pkg::REG_BLUE_SIZE:     chan_size[CH_BLUE] = value[3:0];
            pab_pkg::REG_SCREEN_WIDTH:  scr_width = value[14:0];
            pab_pkg::REG_SCREEN_HEIGHT: scr_height = value[14:0];
            default: ;
        endcase
    endtask

    task automatic load_format(input logic [4:0] rs, input logic [3:0] rz,
                               input logic [4:0] gs, input logic [3:0] gz,
                               input logic [4:0] bs, input logic [3:0] bz,
                               input logic [14:0] w, input logic [14:0] h);
        apb_write(pab_pkg::REG_RED_SHIFT, 32'(rs));
        apb_write(pab_pkg::REG_RED_SIZE, 32'(rz));
        apb_write(pab_pkg::REG_GREEN_SHIFT, 32'(gs));
        apb_write(pab_pkg::REG_GREEN_SIZE, 32'(gz));
        apb_write(pab_pkg::REG_BLUE_SHIFT, 32'(bs));
        apb_write(pab_pkg::REG_BLUE_SIZE, 32'(bz));
        apb_write(pab_pkg::REG_SCREEN_WIDTH, 32'(w));
        apb_write(pab_pkg::REG_SCREEN_HEIGHT, 32'(h));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        format_count++;
    endtask

    task automatic load_random_format();
        logic [3:0]  sz [3];
        logic [4:0]  sh [3];
        logic [14:0] w;
        logic [14:0] h;
        int base;
        if ($urandom_range(1)) begin
            // A realistic layout: blue, green, red packed upward from some offset.
            for (int c = 0; c < 3; c++)
                sz[c] = 4'($urandom_range(1, 8));
            base = $urandom_range(32 - (int'(sz[0]) + int'(sz[1]) + int'(sz[2])));
            sh[CH_BLUE]  = 5'(base);
            sh[CH_GREEN] = 5'(base + int'(sz[CH_BLUE]));
            sh[CH_RED]   = 5'(int'(sh[CH_GREEN]) + int'(sz[CH_GREEN]));
        end else begin
            for (int c = 0; c < 3; c++) begin
                sh[c] = 5'($urandom_range(31));
                sz[c] = 4'(($urandom_range(3) == 0) ? $urandom_range(15)
                                                    : $urandom_range(1, 8));
            end
        end
        w = 15'($urandom_range(1) ? $urandom_range(1, 64) : $urandom_range(1, 32767));
        h = 15'($urandom_range(1) ? $urandom_range(1, 64) : $urandom_range(1, 32767));
        load_format(sh[CH_RED], sz[CH_RED], sh[CH_GREEN], sz[CH_GREEN],
                    sh[CH_BLUE], sz[CH_BLUE], w, h);
    endtask

    // Reset format (RGB888 on 640 x 480): edges, alpha extremes, color extremes.
    task automatic test_directed();
        send_pixel(make_pixel(0, 0, 32'hFFFF_FFFF, 8'd128, 32'h0000_0000));
        send_pixel(make_pixel(639, 479, 32'h0000_0000, 8'd1, 32'hFFFF_FFFF));
        send_pixel(make_pixel(640, 0, 32'h1234_5678, 8'd255, 32'h0000_0000));
        send_pixel(make_pixel(0, 480, 32'h1234_5678, 8'd100, 32'h8765_4321));
        send_pixel(make_pixel(-1, 0, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF));
        send_pixel(make_pixel(0, -1, 32'hFFFF_FFFF, 8'd50, 32'h0000_0000));
        send_pixel(make_pixel(-32768, -32768, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF));
        send_pixel(make_pixel(32767, 32767, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF));
        send_pixel(make_pixel(320, 240, 32'hDEAD_BEEF, 8'd0, 32'h0BAD_F00D));
        // Full alpha must keep the bits above the red field as well.
        send_pixel(make_pixel(1, 2, 32'hAABB_CCDD, 8'd255, 32'h0000_0000));
        send_pixel(make_pixel(5, 5, 32'h00FF_00FF, 8'd254, 32'hFF00_FF00));
        send_pixel(make_pixel(6, 7, 32'h0080_8080, 8'd127, 32'h007F_7F7F));
        send_pixel(make_pixel(10, 400, 32'h0000_0000, 8'd200, 32'h0000_0000));
        send_pixel(make_pixel(600, 3, 32'hFFFF_FFFF, 8'd77, 32'hFFFF_FFFF));
        send_pixel(make_pixel(639, 0, 32'h5555_5555, 8'd2, 32'hAAAA_AAAA));
        send_pixel(make_pixel(0, 479, 32'hAAAA_AAAA, 8'd253, 32'h5555_5555));
        repeat (5)
            send_pixel(make_pixel($urandom_range(639), $urandom_range(479), $urandom,
                                  8'($urandom_range(255)), $urandom));
    endtask

    task automatic test_format_corners();
        wait_drained();
        // RGB565 on a one-pixel screen.
        load_format(5'd11, 4'd5, 5'd5, 4'd6, 5'd0, 4'd5, 15'd1, 15'd1);
        repeat (12) send_pixel(random_pixel());
        wait_drained();
        load_format(5'd0, 4'd1, 5'd1, 4'd2, 5'd3, 4'd3, 15'd32767, 15'd32767);
        repeat (12) send_pixel(random_pixel());
        wait_drained();
        // Red absent, green wider than eight bits, blue mostly shifted off the top;
        // a zero width keeps every coordinate off screen.
        load_format(5'd8, 4'd0, 5'd16, 4'd12, 5'd31, 4'd7, 15'd0, 15'd5);
        repeat (12) send_pixel(random_pixel());
        wait_drained();
        load_format(5'd4, 4'd8, 5'd0, 4'd8, 5'd2, 4'd4, 15'd7, 15'd0);
        repeat (12) send_pixel(random_pixel());
        wait_drained();
        load_format(5'd31, 4'd8, 5'd30, 4'd15, 5'd28, 4'd4, 15'd32767, 15'd1);
        repeat (12) send_pixel(random_pixel());
    endtask

    task automatic test_random_stream(input int send_pct, input int recv_pct,
                                      input int sets, input int per_set);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (sets) begin
            wait_drained();
            load_random_format();
            repeat (per_set)
                send_pixel(random_pixel());
        end
    endtask

    // The receiver stops for a long stretch while pixels keep coming, so the
    // pipeline fills and the input has to stall.
    task automatic test_backpressure();
        wait_drained();
        load_random_format();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 60;
        repeat (40)
            send_pixel(random_pixel());
    endtask

    initial begin
        chan_shift[CH_RED]   = pab_pkg::RST_RED_SHIFT;
        chan_size[CH_RED]    = pab_pkg::RST_RED_SIZE;
        chan_shift[CH_GREEN] = pab_pkg::RST_GREEN_SHIFT;
        chan_size[CH_GREEN]  = pab_pkg::RST_GREEN_SIZE;
        chan_shift[CH_BLUE]  = pab_pkg::RST_BLUE_SHIFT;
        chan_size[CH_BLUE]   = pab_pkg::RST_BLUE_SIZE;
        scr_width            = pab_pkg::RST_SCREEN_WIDTH;
        scr_height           = pab_pkg::RST_SCREEN_HEIGHT;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_format_corners();
        test_random_stream(30, 86, 4, 60);
        test_random_stream(86, 30, 4, 60);
        test_random_stream(0, 0, 4, 60);
        test_backpressure();

        wait_drained();
        repeat (pab_pkg::NUM_STAGES * 4) @(posedge aclk);
        $display("Blended %0d pixels under %0d pixel formats and screen sizes.",
                 pixel_count, format_count);
        $display("The input was held off for %0d cycles by output back-pressure.",
                 stall_cycles);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
